>>> src/cop_pkg.sv
// Shared types, constants and codes for the circle obstacle point projector.
// Used by every module of the block but cop_ram; depends on nothing.

package cop_pkg;

   localparam int CB            = 16;
   localparam int RW            = 14;
   localparam int SLOTW         = 6;
   localparam int CNTW          = 7;
   localparam int NUDW          = 6;
   localparam int CSRW          = 7;
   localparam int CSR_IDXW      = 1;
   localparam int OBSTACLES_DEF = 64;

   localparam logic [CNTW-1:0] COUNT_RST = 7'd0;
   localparam logic [NUDW-1:0] NUDGE_RST = 6'd6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDXW-1:0] CSR_COUNT = 1'b0;
   localparam logic [CSR_IDXW-1:0] CSR_NUDGE = 1'b1;

   localparam logic [1:0] SEL_WRITE = 2'd0;
   localparam logic [1:0] SEL_PASS  = 2'd1;
   localparam logic [1:0] SEL_PROJ  = 2'd2;

   localparam int QW         = 2 * RW;
   localparam int NUMW       = 2 * QW + 2;
   localparam int SUMW       = 2 * RW + 1;
   localparam int QUOW       = 2 * RW + 2;
   localparam int ROOTW      = RW + 1;
   localparam int SREMW      = RW + 4;
   localparam int DIV_STEPS  = QUOW;
   localparam int SQRT_STEPS = QUOW / 2;
   localparam int STEPW      = 5;

   typedef struct packed {
      logic                 op;
      logic [SLOTW-1:0]     slot;
      logic signed [CB-1:0] point_x;
      logic signed [CB-1:0] point_y;
      logic [RW-1:0]        radius;
      logic                 active;
   } req_type;

   typedef struct packed {
      logic                 inside_res;
      logic [SLOTW-1:0]     hit_slot;
      logic signed [CB-1:0] out_x;
      logic signed [CB-1:0] out_y;
   } rsp_type;

   typedef struct packed {
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic [RW-1:0]        r;
      logic                 act;
   } obst_type;

   localparam int OBST_W = $bits(obst_type);

   typedef struct packed {
      logic       clr_run;
      logic       tbl_write;
      logic       scan_init;
      logic       scan_run;
      logic       ld_q;
      logic       ld_num;
      logic       div_step;
      logic       sqrt_step;
      logic       rsp_load;
      logic [1:0] rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic hit;
      logic hit_center;
      logic scan_empty;
   } sts_type;

endpackage

>>> src/cop_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.

module cop_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/cop_lane.sv
// One projection lane: offset magnitude round(a*r/sqrt(s)) by a product,
// a restoring divide and a digit-by-digit square root. Uses cop_pkg.

module cop_lane (
   input  logic                        clock,
   input  cop_pkg::cmd_type            cmd,
   input  logic [cop_pkg::RW-1:0]      a,
   input  logic [cop_pkg::RW-1:0]      r,
   input  logic [cop_pkg::SUMW-1:0]    s,
   output logic [cop_pkg::ROOTW-1:0]   offset
);

   logic [cop_pkg::QW-1:0]    q_ff, q_in;
   logic [cop_pkg::SUMW-1:0]  rem_ff, rem_in;
   logic [cop_pkg::QUOW-1:0]  quo_ff, quo_in;
   logic [cop_pkg::SREMW-1:0] srem_ff, srem_in;
   logic [cop_pkg::ROOTW-1:0] root_ff, root_in;

   logic [2*cop_pkg::QW-1:0]  qsq;
   logic [cop_pkg::NUMW-1:0]  num;
   logic [cop_pkg::QUOW-1:0]  dt;
   logic                      dge;
   logic [cop_pkg::SREMW-1:0] sr;
   logic [cop_pkg::SREMW-1:0] trial;
   logic                      sge;
   logic [cop_pkg::ROOTW:0]   rnd;

   always_comb begin
      qsq   = q_ff * q_ff;
      num   = {qsq, 2'b00};
      dt    = {rem_ff, quo_ff[cop_pkg::QUOW-1]};
      dge   = dt >= {1'b0, s};
      sr    = {srem_ff[cop_pkg::SREMW-3:0], quo_ff[cop_pkg::QUOW-1 -: 2]};
      trial = {2'b00, root_ff[cop_pkg::ROOTW-2:0], 2'b01};
      sge   = sr >= trial;

      q_in    = q_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      if (cmd.ld_q) begin
         q_in = a * r;
      end
      if (cmd.ld_num) begin
         rem_in  = cop_pkg::SUMW'(num[cop_pkg::NUMW-1:cop_pkg::QUOW]);
         quo_in  = num[cop_pkg::QUOW-1:0];
         srem_in = '0;
         root_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = dge ? cop_pkg::SUMW'(dt - {1'b0, s}) : cop_pkg::SUMW'(dt);
         quo_in = {quo_ff[cop_pkg::QUOW-2:0], dge};
      end
      if (cmd.sqrt_step) begin
         srem_in = sge ? sr - trial : sr;
         root_in = {root_ff[cop_pkg::ROOTW-2:0], sge};
         quo_in  = {quo_ff[cop_pkg::QUOW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign rnd    = {1'b0, root_ff} + {{cop_pkg::ROOTW{1'b0}}, 1'b1};
   assign offset = rnd[cop_pkg::ROOTW:1];

endmodule

>>> src/cop_dp.sv
// Datapath: settings registers, obstacle table, scan pipeline, hit capture,
// two projection lanes and the result register. Uses cop_pkg, cop_ram, cop_lane.

module cop_dp #(
   parameter int OBSTACLES = cop_pkg::OBSTACLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cop_pkg::req_type              req_data,
   input  logic                          csr_we,
   input  logic [cop_pkg::CSR_IDXW-1:0]  csr_index,
   input  logic [cop_pkg::CSRW-1:0]      csr_wdata,
   input  cop_pkg::cmd_type              cmd,
   output cop_pkg::sts_type              sts,
   output logic                          rsp_strobe,
   output cop_pkg::rsp_type              rsp_data
);

   localparam int IW  = $clog2(OBSTACLES);
   localparam int SCW = $clog2(OBSTACLES + 1);
   localparam int CB  = cop_pkg::CB;
   localparam int RW  = cop_pkg::RW;

   typedef struct packed {
      logic [IW-1:0]        idx;
      logic signed [CB-1:0] cx;
      logic signed [CB-1:0] cy;
      logic [RW-1:0]        r;
      logic [RW-1:0]        ax;
      logic [RW-1:0]        ay;
      logic                 near;
      logic                 xpos;
      logic                 xneg;
      logic                 ypos;
      logic                 yneg;
   } stg_type;

   function automatic logic signed [CB-1:0] sat(input logic signed [CB+1:0] v);
      logic signed [CB+1:0] hi;
      logic signed [CB+1:0] lo;
      hi = (CB+2)'({1'b0, {(CB-1){1'b1}}});
      lo = -hi - 1;
      if (v > hi) begin
         return hi[CB-1:0];
      end else if (v < lo) begin
         return lo[CB-1:0];
      end
      return v[CB-1:0];
   endfunction

   logic [cop_pkg::CNTW-1:0] count_ff, count_in;
   logic [cop_pkg::NUDW-1:0] nudge_ff, nudge_in;
   logic [IW-1:0]            clr_addr_ff, clr_addr_in;
   logic [SCW-1:0]           idx_ff, idx_in;
   logic                     v0_ff, v1_ff, v2_ff, hit_ff;
   logic                     v0_in, v1_in, v2_in, hit_in;
   logic [IW-1:0]            idx0_ff;
   logic signed [CB-1:0]     px_ff, py_ff;
   stg_type                  s1_ff, s2_ff, h_ff, s1_in;
   logic [2*RW-1:0]          sqx_ff, sqy_ff, sqr_ff;
   logic [cop_pkg::SUMW-1:0] hs_ff, ssum;
   logic                     rsp_valid_ff;
   cop_pkg::rsp_type         rsp_ff, rsp_in;

   logic [cop_pkg::CNTW-1:0] endm;
   logic [SCW-1:0]           scan_end;
   logic                     issue;
   logic                     slot_ok;
   logic                     ram_we;
   logic [IW-1:0]            ram_waddr;
   logic [cop_pkg::OBST_W-1:0] ram_wdata, ram_rdata;
   cop_pkg::obst_type        ent, wr_ent;
   logic signed [CB:0]       dx, dy;
   logic [CB:0]              adx, ady;
   logic                     hit_now;
   logic [cop_pkg::ROOTW-1:0] ox, oy;
   logic signed [CB+1:0]     magx, magy, offx, offy, nx, ny;

   always_comb begin
      count_in = count_ff;
      nudge_in = nudge_ff;
      if (csr_we) begin
         unique case (csr_index)
            cop_pkg::CSR_COUNT: count_in = csr_wdata;
            cop_pkg::CSR_NUDGE: nudge_in = csr_wdata[cop_pkg::NUDW-1:0];
            default:            count_in = count_ff;
         endcase
      end
   end

   assign clr_addr_in = cmd.clr_run ? clr_addr_ff + IW'(1) : clr_addr_ff;

   assign slot_ok = int'(req_data.slot) < OBSTACLES;
   always_comb begin
      wr_ent.cx  = req_data.point_x;
      wr_ent.cy  = req_data.point_y;
      wr_ent.r   = req_data.radius;
      wr_ent.act = req_data.active;
   end
   assign ram_we    = cmd.clr_run | (cmd.tbl_write & slot_ok);
   assign ram_waddr = cmd.clr_run ? clr_addr_ff : IW'(req_data.slot);
   assign ram_wdata = cmd.clr_run ? '0 : wr_ent;

   cop_ram #(
      .WIDTH(cop_pkg::OBST_W),
      .DEPTH(OBSTACLES)
   ) u_table (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(idx_ff[IW-1:0]),
      .rdata(ram_rdata)
   );

   assign endm     = (count_ff != '0) ? count_ff - cop_pkg::CNTW'(1) : '0;
   assign scan_end = (int'(endm) > OBSTACLES) ? SCW'(OBSTACLES) : SCW'(endm);
   assign issue    = cmd.scan_run && (idx_ff < scan_end);

   always_comb begin
      ent = cop_pkg::obst_type'(ram_rdata);
      dx  = $signed({px_ff[CB-1], px_ff}) - $signed({ent.cx[CB-1], ent.cx});
      dy  = $signed({py_ff[CB-1], py_ff}) - $signed({ent.cy[CB-1], ent.cy});
      adx = dx[CB] ? unsigned'(-dx) : unsigned'(dx);
      ady = dy[CB] ? unsigned'(-dy) : unsigned'(dy);
      s1_in.idx  = idx0_ff;
      s1_in.cx   = ent.cx;
      s1_in.cy   = ent.cy;
      s1_in.r    = ent.r;
      s1_in.ax   = adx[RW-1:0];
      s1_in.ay   = ady[RW-1:0];
      s1_in.near = ent.act && (adx < (CB+1)'(ent.r)) && (ady < (CB+1)'(ent.r));
      s1_in.xpos = !dx[CB] && (dx != '0);
      s1_in.xneg = dx[CB];
      s1_in.ypos = !dy[CB] && (dy != '0);
      s1_in.yneg = dy[CB];
   end

   assign ssum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign hit_now = v2_ff && s2_ff.near && (ssum < {1'b0, sqr_ff}) && !hit_ff;

   always_comb begin
      idx_in = idx_ff;
      v0_in  = issue;
      v1_in  = v0_ff;
      v2_in  = v1_ff;
      hit_in = hit_ff | hit_now;
      if (issue) begin
         idx_in = idx_ff + SCW'(1);
      end
      if (cmd.scan_init) begin
         idx_in = SCW'(1);
         v0_in  = 1'b0;
         v1_in  = 1'b0;
         v2_in  = 1'b0;
         hit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= cop_pkg::COUNT_RST;
         nudge_ff     <= cop_pkg::NUDGE_RST;
         clr_addr_ff  <= '0;
         idx_ff       <= '0;
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         nudge_ff     <= nudge_in;
         clr_addr_ff  <= clr_addr_in;
         idx_ff       <= idx_in;
         v0_ff        <= v0_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      idx0_ff <= idx_ff[IW-1:0];
      s1_ff   <= s1_in;
      s2_ff   <= s1_ff;
      sqx_ff  <= s1_ff.ax * s1_ff.ax;
      sqy_ff  <= s1_ff.ay * s1_ff.ay;
      sqr_ff  <= s1_ff.r * s1_ff.r;
      if (cmd.scan_init) begin
         px_ff <= req_data.point_x;
         py_ff <= req_data.point_y;
      end
      if (hit_now) begin
         h_ff  <= s2_ff;
         hs_ff <= ssum;
      end
      rsp_ff <= rsp_in;
   end

   cop_lane u_lane_x (
      .clock(clock),
      .cmd(cmd),
      .a(h_ff.ax),
      .r(h_ff.r),
      .s(hs_ff),
      .offset(ox)
   );

   cop_lane u_lane_y (
      .clock(clock),
      .cmd(cmd),
      .a(h_ff.ay),
      .r(h_ff.r),
      .s(hs_ff),
      .offset(oy)
   );

   always_comb begin
      magx = (CB+2)'(ox) + (CB+2)'(nudge_ff);
      magy = (CB+2)'(oy) + (CB+2)'(nudge_ff);
      priority if (!(h_ff.xpos | h_ff.xneg | h_ff.ypos | h_ff.yneg)) begin
         offx = (CB+2)'(h_ff.r) + (CB+2)'(nudge_ff);
      end else if (h_ff.xpos) begin
         offx = magx;
      end else if (h_ff.xneg) begin
         offx = -magx;
      end else begin
         offx = '0;
      end
      priority if (h_ff.ypos) begin
         offy = magy;
      end else if (h_ff.yneg) begin
         offy = -magy;
      end else begin
         offy = '0;
      end
      nx = $signed({{2{h_ff.cx[CB-1]}}, h_ff.cx}) + offx;
      ny = $signed({{2{h_ff.cy[CB-1]}}, h_ff.cy}) + offy;

      rsp_in = rsp_ff;
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            cop_pkg::SEL_PASS: begin
               rsp_in.inside_res = 1'b0;
               rsp_in.hit_slot   = '0;
               rsp_in.out_x      = px_ff;
               rsp_in.out_y      = py_ff;
            end
            cop_pkg::SEL_PROJ: begin
               rsp_in.inside_res = 1'b1;
               rsp_in.hit_slot   = cop_pkg::SLOTW'(h_ff.idx);
               rsp_in.out_x      = sat(nx);
               rsp_in.out_y      = sat(ny);
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   assign sts.clr_done   = clr_addr_ff == IW'(OBSTACLES - 1);
   assign sts.hit        = hit_ff;
   assign sts.hit_center = !(h_ff.xpos | h_ff.xneg | h_ff.ypos | h_ff.yneg);
   assign sts.scan_empty = !hit_ff && !(idx_ff < scan_end) && !v0_ff && !v1_ff && !v2_ff;

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

>>> src/cop_ctrl.sv
// Controller state machine: table clearing, request dispatch, scan and the
// projection sequence. Uses cop_pkg for command and status types.

module cop_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_op,
   input  cop_pkg::sts_type sts,
   output cop_pkg::cmd_type cmd,
   output logic             busy
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_MULQ  = 3'd3;
   localparam logic [2:0] ST_MULN  = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_SQRT  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]                 state_ff, state_in;
   logic [cop_pkg::STEPW-1:0]  step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_run = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_op == cop_pkg::OP_WRITE) begin
                  cmd.tbl_write = 1'b1;
                  cmd.rsp_load  = 1'b1;
                  cmd.rsp_sel   = cop_pkg::SEL_WRITE;
               end else begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            priority if (sts.hit) begin
               state_in = sts.hit_center ? ST_DONE : ST_MULQ;
            end else if (sts.scan_empty) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = cop_pkg::SEL_PASS;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_MULQ: begin
            cmd.ld_q = 1'b1;
            state_in = ST_MULN;
         end
         ST_MULN: begin
            cmd.ld_num = 1'b1;
            step_in    = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + cop_pkg::STEPW'(1);
            if (step_ff == cop_pkg::STEPW'(cop_pkg::DIV_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            step_in       = step_ff + cop_pkg::STEPW'(1);
            if (step_ff == cop_pkg::STEPW'(cop_pkg::SQRT_STEPS - 1)) begin
               step_in  = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = cop_pkg::SEL_PROJ;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign busy = state_ff != ST_IDLE;

endmodule

>>> src/circle_obstacle_point_projector.sv
// Top level of the circle obstacle point projector: controller plus datapath.
// Uses cop_pkg, cop_ctrl and cop_dp.
//
// A request is taken at a clock edge where start is high and busy is low.
// A write request (op 0) stores one obstacle slot; its result, all zero, shows
// on rsp_strobe/rsp_data in the next cycle and busy never rises.
// A query request (op 1) scans slots 1 to obstacle_count-2 through the table
// RAM, one slot a cycle with a three-stage test pipeline behind the read.
// With no hit the result follows once every scanned slot has left the test
// pipeline. A hit is followed by a projection before the result is given:
// two multiplies, a 30-step divide and a 15-step square root per axis, both
// axes in parallel; a hit on the exact center skips it. The longest query,
// from request to result, is one with a hit on slot 63.
// Each result is on rsp_data for exactly one cycle with rsp_strobe high; the
// receiver cannot stall it. The user writes settings through csr_we, csr_index
// and csr_wdata while the block is idle, which the block does not enforce.
// After reset the table is cleared one slot a cycle, all OBSTACLES slots, with
// busy high; settings writes are taken during that time.

module circle_obstacle_point_projector #(
   parameter int OBSTACLES = cop_pkg::OBSTACLES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  cop_pkg::req_type              req_data,
   output logic                          rsp_strobe,
   output cop_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [cop_pkg::CSR_IDXW-1:0]  csr_index,
   input  logic [cop_pkg::CSRW-1:0]      csr_wdata
);

   cop_pkg::cmd_type cmd;
   cop_pkg::sts_type sts;

   cop_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_op(req_data.op),
      .sts(sts),
      .cmd(cmd),
      .busy(busy)
   );

   cop_dp #(
      .OBSTACLES(OBSTACLES)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd(cmd),
      .sts(sts),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

endmodule

>>> src/cop_checker.sv
// Port-level checks for the circle obstacle point projector, bound to the top.
// Uses cop_pkg for the request and result types and operation codes.

module cop_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input cop_pkg::req_type req_data,
   input logic             rsp_strobe,
   input cop_pkg::rsp_type rsp_data
);

   a_write_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == cop_pkg::OP_WRITE) |=>
      (rsp_strobe && !rsp_data.inside_res && rsp_data.hit_slot == '0 &&
       rsp_data.out_x == '0 && rsp_data.out_y == '0))
      else $error("write request did not give an all-zero result next cycle");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == cop_pkg::OP_QUERY) |=> busy)
      else $error("query request did not make the block busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while the block is still busy");

   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.inside_res) |-> rsp_data.hit_slot == '0)
      else $error("result without a hit carries a nonzero slot");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> busy)
      else $error("block not busy clearing the table after reset");

endmodule

bind circle_obstacle_point_projector cop_checker u_cop_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .req_data(req_data),
   .rsp_strobe(rsp_strobe),
   .rsp_data(rsp_data)
);
